@@ rtl/srt_pkg.sv @@
// Shared constants, request and status codes, and the controller command bundle
// for sorted_record_table. It depends on nothing else.
package srt_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int ID_W     = 27;
	localparam int SEX_W    = 8;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_POP    = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the accepted request
		logic compare;  // register the per-entry key compares
		logic execute;  // update the table and load the result register
	} srt_cmd_t;

endpackage

@@ rtl/srt_ctrl.sv @@
// Request sequencer for sorted_record_table: accept, compare, execute.
// Depends on srt_pkg.
module srt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output srt_pkg::srt_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   slot_free;

	// The result register can take a new result when it is empty or being emptied.
	assign slot_free = !out_valid_q || out_ready;

	assign cmd.capture = in_valid && in_ready_q;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.execute = (state_q == S_EXEC) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_CMP;
						in_ready_q <= 1'b0;
					end
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (slot_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A new result sets the flag; a taken result with nothing behind it clears it.
			if (cmd.execute)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> state_q == S_IDLE)
		else $error("in_ready high outside the idle state");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");
	a_exec_follows_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |=> state_q == S_EXEC)
		else $error("compare step not followed by execute step");
`endif

endmodule

@@ rtl/srt_datapath.sv @@
// Sorted record cells, parallel key compares and the result register of
// sorted_record_table. Depends on srt_pkg.
module srt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  srt_pkg::srt_cmd_t                 cmd,
	input  logic [1:0]                        req_type,
	input  logic signed [srt_pkg::KEY_W-1:0]  rec_key,
	input  logic [srt_pkg::ID_W-1:0]          rec_id_number,
	input  logic [srt_pkg::SEX_W-1:0]         rec_sex,
	output logic [1:0]                        status,
	output logic signed [srt_pkg::KEY_W-1:0]  out_key,
	output logic [srt_pkg::ID_W-1:0]          out_id_number,
	output logic [srt_pkg::SEX_W-1:0]         out_sex,
	output logic [srt_pkg::CNT_W-1:0]         fill_count
);

	localparam int N = srt_pkg::CAPACITY;

	// Latched request.
	srt_pkg::req_t                    req_q;
	logic signed [srt_pkg::KEY_W-1:0] key_in_q;
	logic [srt_pkg::ID_W-1:0]         id_in_q;
	logic [srt_pkg::SEX_W-1:0]        sex_in_q;

	// Table cells, kept in ascending key order from cell zero.
	logic signed [srt_pkg::KEY_W-1:0] key_q [N];
	logic [srt_pkg::ID_W-1:0]         id_q  [N];
	logic [srt_pkg::SEX_W-1:0]        sex_q [N];
	logic [srt_pkg::CNT_W-1:0]        count_q;

	// Registered compare vectors.
	logic [N-1:0] lt_s1;
	logic [N-1:0] eq_s1;

	// Result register.
	srt_pkg::status_t                 status_q;
	logic signed [srt_pkg::KEY_W-1:0] out_key_q;
	logic [srt_pkg::ID_W-1:0]         out_id_q;
	logic [srt_pkg::SEX_W-1:0]        out_sex_q;
	logic [srt_pkg::CNT_W-1:0]        fill_q;

	logic [N-1:0]                     held;
	logic [N-1:0]                     first_hit;
	logic                             full;
	logic                             empty;
	logic signed [srt_pkg::KEY_W-1:0] hit_key;
	logic [srt_pkg::ID_W-1:0]         hit_id;
	logic [srt_pkg::SEX_W-1:0]        hit_sex;

	always_comb begin
		for (int i = 0; i < N; i++)
			held[i] = srt_pkg::CNT_W'(i) < count_q;
	end

	assign full  = (count_q == srt_pkg::CNT_W'(N));
	assign empty = (count_q == '0);

	// Lowest set bit of the equal vector picks the first matching record.
	assign first_hit = eq_s1 & (~eq_s1 + N'(1));

	always_comb begin
		hit_key = '0;
		hit_id  = '0;
		hit_sex = '0;
		for (int i = 0; i < N; i++) begin
			if (first_hit[i]) begin
				hit_key = hit_key | key_q[i];
				hit_id  = hit_id  | id_q[i];
				hit_sex = hit_sex | sex_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= srt_pkg::req_t'(req_type);
			key_in_q <= rec_key;
			id_in_q  <= rec_id_number;
			sex_in_q <= rec_sex;
		end
		if (cmd.compare) begin
			for (int i = 0; i < N; i++) begin
				lt_s1[i] <= held[i] && (key_q[i] < key_in_q);
				eq_s1[i] <= held[i] && (key_q[i] == key_in_q);
			end
		end
		if (cmd.execute) begin
			unique case (req_q)
				srt_pkg::REQ_INSERT: begin
					// Cells below the insert point keep their record; the insert
					// point takes the new one and every cell above takes its lower
					// neighbor's record.
					if (!full) begin
						for (int i = 0; i < N; i++) begin
							if (!lt_s1[i]) begin
								if (i == 0 || lt_s1[(i == 0) ? 0 : i - 1]) begin
									key_q[i] <= key_in_q;
									id_q[i]  <= id_in_q;
									sex_q[i] <= sex_in_q;
								end else begin
									key_q[i] <= key_q[(i == 0) ? 0 : i - 1];
									id_q[i]  <= id_q[(i == 0) ? 0 : i - 1];
									sex_q[i] <= sex_q[(i == 0) ? 0 : i - 1];
								end
							end
						end
					end
					status_q  <= full ? srt_pkg::ST_FULL : srt_pkg::ST_OK;
					out_key_q <= '0;
					out_id_q  <= '0;
					out_sex_q <= '0;
				end
				srt_pkg::REQ_SEARCH: begin
					status_q  <= (eq_s1 != '0) ? srt_pkg::ST_OK : srt_pkg::ST_NOT_FOUND;
					out_key_q <= hit_key;
					out_id_q  <= hit_id;
					out_sex_q <= hit_sex;
				end
				srt_pkg::REQ_POP: begin
					if (!empty) begin
						for (int i = 0; i < N - 1; i++) begin
							key_q[i] <= key_q[i + 1];
							id_q[i]  <= id_q[i + 1];
							sex_q[i] <= sex_q[i + 1];
						end
					end
					status_q  <= empty ? srt_pkg::ST_EMPTY : srt_pkg::ST_OK;
					out_key_q <= empty ? '0 : key_q[0];
					out_id_q  <= empty ? '0 : id_q[0];
					out_sex_q <= empty ? '0 : sex_q[0];
				end
				srt_pkg::REQ_NOP: begin
					status_q  <= srt_pkg::ST_OK;
					out_key_q <= '0;
					out_id_q  <= '0;
					out_sex_q <= '0;
				end
				default: begin
					status_q  <= srt_pkg::ST_OK;
					out_key_q <= '0;
					out_id_q  <= '0;
					out_sex_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
		end else if (cmd.execute) begin
			if (req_q == srt_pkg::REQ_INSERT && !full) begin
				count_q <= count_q + srt_pkg::CNT_W'(1);
				fill_q  <= count_q + srt_pkg::CNT_W'(1);
			end else if (req_q == srt_pkg::REQ_POP && !empty) begin
				count_q <= count_q - srt_pkg::CNT_W'(1);
				fill_q  <= count_q - srt_pkg::CNT_W'(1);
			end else begin
				fill_q  <= count_q;
			end
		end
	end

	assign status        = status_q;
	assign out_key       = out_key_q;
	assign out_id_number = out_id_q;
	assign out_sex       = out_sex_q;
	assign fill_count    = fill_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= srt_pkg::CNT_W'(N))
		else $error("record count beyond capacity");
	a_lt_on_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> ((lt_s1 & ~held) == '0) && ((eq_s1 & ~held) == '0))
		else $error("compare hit on an empty cell");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.execute |=> $stable(count_q))
		else $error("record count changed outside execute");
`endif

endmodule

@@ rtl/sorted_record_table.sv @@
// Top level of sorted_record_table: a 16-entry table of records kept sorted by
// signed key. Depends on srt_pkg, srt_ctrl and srt_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_ready  | req_type, rec_key, rec_id_number, rec_sex
//  result   | out_valid / out_ready| status, out_key, out_id_number, out_sex,
//           |                      | fill_count
//
// Each request goes through an accept step, a compare step in which every held
// cell compares its key against the request key in parallel, and an execute
// step that shifts the cells (insert or pop) and loads the result register.
// The compare register sits between the cells and the shift network.
// arst_n clears the record count and the handshake state; cell contents are
// not reset, and only cells below the count ever reach the result.
// While a result waits in the result register a new request is still taken;
// its execute step waits until the old result is taken.
module sorted_record_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic signed [srt_pkg::KEY_W-1:0]  rec_key,
	input  logic [srt_pkg::ID_W-1:0]          rec_id_number,
	input  logic [srt_pkg::SEX_W-1:0]         rec_sex,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [srt_pkg::KEY_W-1:0]  out_key,
	output logic [srt_pkg::ID_W-1:0]          out_id_number,
	output logic [srt_pkg::SEX_W-1:0]         out_sex,
	output logic [srt_pkg::CNT_W-1:0]         fill_count
);

	// Command bundle: the controller never looks at data, the datapath never
	// looks at the handshake.
	srt_pkg::srt_cmd_t cmd;

	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the sorted cells, the per-cell comparators and the
	// result register; an insert lands in front of the first key that is not
	// smaller, so equal keys come out newest first.
	srt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_type      (req_type),
		.rec_key       (rec_key),
		.rec_id_number (rec_id_number),
		.rec_sex       (rec_sex),
		.status        (status),
		.out_key       (out_key),
		.out_id_number (out_id_number),
		.out_sex       (out_sex),
		.fill_count    (fill_count)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request accepted while one is in progress");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status) && $stable(out_key)
			&& $stable(out_id_number) && $stable(out_sex) && $stable(fill_count))
		else $error("waiting result dropped or changed");
`endif

endmodule

@@ sim/tb_sorted_record_table.sv @@
// Self-checking testbench for sorted_record_table: directed and random requests
// against a sorted-record predictor held in a small scoreboard class.
// Depends on srt_pkg and the sorted_record_table RTL.
module tb_sorted_record_table;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 1875;
	localparam int LONG_HOLD = 250;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		srt_pkg::status_t                 st;
		logic signed [srt_pkg::KEY_W-1:0] key;
		logic [srt_pkg::ID_W-1:0]         idn;
		logic [srt_pkg::SEX_W-1:0]        sx;
		logic [srt_pkg::CNT_W-1:0]        fill;
	} record_result_t;

	// Keeps its own copy of the sorted table and predicts one result per
	// accepted request.
	class sorted_records;
		logic signed [srt_pkg::KEY_W-1:0] keys [srt_pkg::CAPACITY];
		logic [srt_pkg::ID_W-1:0]         ids [srt_pkg::CAPACITY];
		logic [srt_pkg::SEX_W-1:0]        sexes [srt_pkg::CAPACITY];
		int                               count;
		int                               errors;
		record_result_t                   pending_results [$];

		function void note_request(srt_pkg::req_t r, logic signed [srt_pkg::KEY_W-1:0] k,
				logic [srt_pkg::ID_W-1:0] idn, logic [srt_pkg::SEX_W-1:0] sx);
			record_result_t res;
			int pos;
			res.st = srt_pkg::ST_OK;
			res.key = '0;
			res.idn = '0;
			res.sx = '0;
			case (r)
				srt_pkg::REQ_INSERT: begin
					if (count >= srt_pkg::CAPACITY) begin
						res.st = srt_pkg::ST_FULL;
					end else begin
						// Go in front of the first key that is not smaller,
						// so the newest of equal keys comes first.
						pos = 0;
						while (pos < count && keys[pos] < k)
							pos++;
						for (int i = count; i > pos; i--) begin
							keys[i] = keys[i-1];
							ids[i] = ids[i-1];
							sexes[i] = sexes[i-1];
						end
						keys[pos] = k;
						ids[pos] = idn;
						sexes[pos] = sx;
						count++;
					end
				end
				srt_pkg::REQ_SEARCH: begin
					res.st = srt_pkg::ST_NOT_FOUND;
					for (int i = 0; i < count; i++) begin
						if (keys[i] == k) begin
							res.st = srt_pkg::ST_OK;
							res.key = keys[i];
							res.idn = ids[i];
							res.sx = sexes[i];
							break;
						end
					end
				end
				srt_pkg::REQ_POP: begin
					if (count == 0) begin
						res.st = srt_pkg::ST_EMPTY;
					end else begin
						res.key = keys[0];
						res.idn = ids[0];
						res.sx = sexes[0];
						for (int i = 1; i < count; i++) begin
							keys[i-1] = keys[i];
							ids[i-1] = ids[i];
							sexes[i-1] = sexes[i];
						end
						count--;
					end
				end
				default: ;
			endcase
			res.fill = srt_pkg::CNT_W'(count);
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [1:0] st, logic signed [srt_pkg::KEY_W-1:0] k,
				logic [srt_pkg::ID_W-1:0] idn, logic [srt_pkg::SEX_W-1:0] sx,
				logic [srt_pkg::CNT_W-1:0] fill);
			record_result_t res;
			if (pending_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
				return;
			end
			res = pending_results.pop_front();
			if (st !== res.st) begin
				$error("status: expected %0d, got %0d", res.st, st);
				errors++;
			end
			if (k !== res.key) begin
				$error("out_key: expected %0d, got %0d", res.key, k);
				errors++;
			end
			if (idn !== res.idn) begin
				$error("out_id_number: expected %0d, got %0d", res.idn, idn);
				errors++;
			end
			if (sx !== res.sx) begin
				$error("out_sex: expected %0d, got %0d", res.sx, sx);
				errors++;
			end
			if (fill !== res.fill) begin
				$error("fill_count: expected %0d, got %0d", res.fill, fill);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [1:0]                        req_type = '0;
	logic signed [srt_pkg::KEY_W-1:0]  rec_key = '0;
	logic [srt_pkg::ID_W-1:0]          rec_id_number = '0;
	logic [srt_pkg::SEX_W-1:0]         rec_sex = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [1:0]                        status;
	logic signed [srt_pkg::KEY_W-1:0]  out_key;
	logic [srt_pkg::ID_W-1:0]          out_id_number;
	logic [srt_pkg::SEX_W-1:0]         out_sex;
	logic [srt_pkg::CNT_W-1:0]         fill_count;

	sorted_records shadow = new();
	int unsigned   accepted_requests = 0;
	int            idle_cycles = 0;
	int            burst_left = 0;

	sorted_record_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.rec_key       (rec_key),
		.rec_id_number (rec_id_number),
		.rec_sex       (rec_sex),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.out_key       (out_key),
		.out_id_number (out_id_number),
		.out_sex       (out_sex),
		.fill_count    (fill_count)
	);

	always #4 clk = ~clk;

	// Offer one request and hold it until the block takes it.
	task automatic send_request(srt_pkg::req_t r, logic signed [srt_pkg::KEY_W-1:0] k,
			logic [srt_pkg::ID_W-1:0] idn, logic [srt_pkg::SEX_W-1:0] sx);
		in_valid <= 1'b1;
		req_type <= r;
		rec_key <= k;
		rec_id_number <= idn;
		rec_sex <= sx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shadow.note_request(r, k, idn, sx);
		accepted_requests++;
	endtask

	// Bursts of random length; some bursts run straight into the next one.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// Mostly a narrow pool so that equal keys and search hits are common.
	function automatic logic signed [srt_pkg::KEY_W-1:0] random_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 24)) - 12;
			6:                return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default:          return $urandom;
		endcase
	endfunction

	initial begin : reset_gen
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The receiver switches between stall patterns and, once, holds off long
	// enough for the block to back up onto its input.
	initial begin : receiver
		int  mode;
		int  left;
		bit  held;
		mode = 0;
		left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_requests >= 400) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			shadow.check_result(status, out_key, out_id_number, out_sex, fill_count);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		srt_pkg::req_t r;
		logic signed [srt_pkg::KEY_W-1:0] k;
		bit grow;
		int phase_left;
		int pick;
		grow = 1'b1;
		phase_left = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Empty table, the no-op request code, and the key extremes.
		send_request(srt_pkg::REQ_POP, 32'sd5, 27'd3, 8'd7);                 pace_sender();
		send_request(srt_pkg::REQ_SEARCH, 32'sd0, 27'd0, 8'd0);              pace_sender();
		send_request(srt_pkg::REQ_NOP, 32'sh7fffffff, 27'd99999999, 8'hff);  pace_sender();
		send_request(srt_pkg::REQ_INSERT, 32'sh7fffffff, 27'd99999999, 8'hff);
		pace_sender();
		send_request(srt_pkg::REQ_INSERT, 32'sh80000000, 27'd0, 8'h00);      pace_sender();
		send_request(srt_pkg::REQ_INSERT, 32'sd0, 27'd67108864, 8'h80);      pace_sender();
		// A second record with the same key must be found first.
		send_request(srt_pkg::REQ_INSERT, 32'sd0, 27'd1, 8'h01);             pace_sender();
		send_request(srt_pkg::REQ_SEARCH, 32'sd0, 27'd0, 8'd0);              pace_sender();
		send_request(srt_pkg::REQ_SEARCH, 32'sh80000000, 27'd0, 8'd0);       pace_sender();
		send_request(srt_pkg::REQ_SEARCH, -32'sd1, 27'd0, 8'd0);             pace_sender();
		// Fill the table, then try one insert too many.
		repeat (srt_pkg::CAPACITY - 4) begin
			send_request(srt_pkg::REQ_INSERT, int'($urandom_range(0, 20)) - 10,
				srt_pkg::ID_W'($urandom_range(0, 99999999)),
				srt_pkg::SEX_W'($urandom_range(0, 255)));
			pace_sender();
		end
		send_request(srt_pkg::REQ_INSERT, 32'sd3, 27'd12345, 8'h55);         pace_sender();
		send_request(srt_pkg::REQ_SEARCH, 32'sh7fffffff, 27'd0, 8'd0);       pace_sender();
		send_request(srt_pkg::REQ_POP, 32'sd0, 27'd0, 8'd0);                 pace_sender();

		// Random part: phases that lean toward filling or draining the table.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (phase_left == 0) begin
				grow = ~grow;
				phase_left = $urandom_range(30, 120);
			end
			phase_left--;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				r = srt_pkg::REQ_NOP;
			else if (pick < 28)
				r = srt_pkg::REQ_SEARCH;
			else if (pick < 80)
				r = grow ? srt_pkg::REQ_INSERT : srt_pkg::REQ_POP;
			else
				r = grow ? srt_pkg::REQ_POP : srt_pkg::REQ_INSERT;
			k = random_key();
			if (r == srt_pkg::REQ_SEARCH && shadow.count > 0 && $urandom_range(0, 9) < 7)
				k = shadow.keys[$urandom_range(0, shadow.count - 1)];
			send_request(r, k, srt_pkg::ID_W'($urandom_range(0, 99999999)),
				srt_pkg::SEX_W'($urandom_range(0, 255)));
			if (n != RANDOM_REQUESTS - 1)
				pace_sender();
		end
		in_valid <= 1'b0;

		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.outstanding() != 0) begin
			$error("%0d results never arrived", shadow.outstanding());
			shadow.errors++;
		end
		if (shadow.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
